/* rtl/hpt_pkg.sv */
// Package: types, constants and helpers for the homogeneous point transform
package hpt_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned MinW    = 17;
  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned Lanes   = 4;
  localparam logic signed [DataW-1:0] OneQ16 = 32'sd65536;
  localparam logic [MinW-1:0] MinWReset = 17'd1;
  localparam int unsigned QuotW   = 49;
  localparam int unsigned DivSteps = QuotW;

  typedef enum logic [1:0] {
    CmdLoad = 2'd0,
    CmdPoint = 2'd1,
    CmdHomog = 2'd2,
    CmdDir = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
    logic last_vector;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic w_clamped;
    logic last_result;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic signed [31:0] in_w;
    logic last;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    if (v < -68'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

/* rtl/hpt_lane.sv */
// One column lane: four products, registered, then summed, rounded and saturated
module hpt_lane import hpt_pkg::*; (
  input  logic               clk_i,
  input  logic               en0_i,
  input  logic               en1_i,
  input  logic signed [31:0] v_i [4],
  input  logic signed [31:0] m_i [4],
  output logic signed [31:0] r_o
);
  logic signed [63:0] p_q [4];
  logic signed [31:0] r_q;
  logic signed [67:0] sum;

  always_ff @(posedge clk_i) begin
    if (en0_i) begin
      for (int k = 0; k < 4; k++) p_q[k] <= v_i[k] * m_i[k];
    end
    if (en1_i) r_q <= sat32(sum);
  end

  always_comb begin
    logic signed [67:0] s;
    s = 68'sd32768;
    for (int k = 0; k < 4; k++) s = s + 68'(p_q[k]);
    sum = s >>> 16;
  end

  assign r_o = r_q;
endmodule

/* rtl/hpt_div.sv */
// Pipelined restoring divider: rounded signed Q16.16 quotient, one bit per stage
module hpt_div import hpt_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic               bypass_i,
  input  logic signed [31:0] n_i,
  input  logic signed [31:0] d_i,
  output logic signed [31:0] q_o
);
  localparam int unsigned NW = 48;
  localparam int unsigned RW = 34;
  logic [NW-1:0] num_q [DivSteps+1];
  logic [RW-1:0] rem_q [DivSteps+1];
  logic [QuotW-1:0] quo_q [DivSteps+1];
  logic [31:0] den_q [DivSteps+1];
  logic neg_q [DivSteps+1];
  logic byp_q [DivSteps+1];
  logic signed [31:0] raw_q [DivSteps+1];
  logic signed [31:0] q_q;
  logic [32:0] un, ud;

  function automatic logic signed [31:0] res(input logic [QuotW-1:0] q, input logic ng);
    logic [QuotW:0] a;
    a = {2'b0, q[QuotW-1:1]} + {{QuotW{1'b0}}, q[0]};
    return sat32(ng ? -68'(a) : 68'(a));
  endfunction

  assign un = n_i[31] ? 33'(-34'(n_i)) : 33'(n_i);
  assign ud = d_i[31] ? 33'(-34'(d_i)) : 33'(d_i);

  // 48 steps give the integer quotient, the last step compares twice the remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= {un[31:0], 16'd0};
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      den_q[0] <= ud[31:0];
      neg_q[0] <= n_i[31] ^ d_i[31];
      byp_q[0] <= bypass_i;
      raw_q[0] <= n_i;
      for (int s = 0; s < DivSteps; s++) begin
        logic [RW:0] t;
        t = {rem_q[s], (s < NW) ? num_q[s][NW-1] : 1'b0};
        if (t >= {3'b0, den_q[s]}) begin
          rem_q[s+1] <= RW'(t - {3'b0, den_q[s]});
          quo_q[s+1] <= {quo_q[s][QuotW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= RW'(t);
          quo_q[s+1] <= {quo_q[s][QuotW-2:0], 1'b0};
        end
        num_q[s+1] <= num_q[s] << 1;
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        byp_q[s+1] <= byp_q[s];
        raw_q[s+1] <= raw_q[s];
      end
      q_q <= byp_q[DivSteps] ? raw_q[DivSteps] : res(quo_q[DivSteps], neg_q[DivSteps]);
    end
  end

  assign q_o = q_q;
endmodule

/* rtl/homogeneous_point_transform.sv */
// Top level: matrix store, four column lanes, clamp, three dividers and output skid
// One vector per cycle while the output skid register is empty. A result passes two lane
// stages, a clamp stage, the divider's input register, 49 quotient steps and its output
// register. Loads take one beat and give no result. The pipeline advances whenever the
// output skid register is empty, so input ready does not depend on output ready.
module homogeneous_point_transform import hpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [MinW-1:0] cfg_data_i
);
  localparam int unsigned Depth = 3 + DivSteps + 2;
  logic signed [31:0] m_q [Entries];
  logic [MinW-1:0] minw_q;
  logic adv;
  logic vld_q [Depth];
  side_t sd_q [Depth];
  logic cl_q [2:Depth-1];
  logic signed [31:0] v [4];
  logic signed [31:0] col [4][4];
  logic signed [31:0] r [4];
  logic signed [31:0] rr_q [4];
  logic signed [31:0] wd_q;
  logic byp_q;
  logic signed [31:0] q [3];
  logic is_vec;
  logic [31:0] mag, mn;
  logic clamp;
  logic pipe_vld;
  out_beat_t pipe_beat;
  out_beat_t skid_q, skid_d;
  logic skid_vld_q, skid_vld_d;

  assign adv = !skid_vld_q;
  assign in_ready_o = adv;
  assign cfg_ready_o = 1'b1;
  assign is_vec = in_valid_i && in_data_i.command != CmdLoad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) m_q[i] <= (i % 5 == 0) ? OneQ16 : '0;
      minw_q <= MinWReset;
    end else begin
      if (in_valid_i && adv && in_data_i.command == CmdLoad)
        m_q[in_data_i.entry_index] <= in_data_i.entry_value;
      if (cfg_valid_i) minw_q <= cfg_data_i;
    end
  end

  always_comb begin
    v[0] = in_data_i.in_x;
    v[1] = in_data_i.in_y;
    v[2] = in_data_i.in_z;
    case (in_data_i.command)
      CmdPoint: v[3] = OneQ16;
      CmdHomog: v[3] = in_data_i.in_w;
      default:  v[3] = '0;
    endcase
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++) col[c][k] = m_q[k*4+c];
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    hpt_lane u_lane (.clk_i, .en0_i(adv), .en1_i(adv), .v_i(v), .m_i(col[c]), .r_o(r[c]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= is_vec;
      for (int i = 1; i < Depth; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_comb begin
    mn = (minw_q == '0) ? 32'd1 : 32'(minw_q);
    mag = r[3][31] ? 32'(-33'(r[3])) : 32'(r[3]);
    clamp = sd_q[1].cmd == CmdPoint && r[3] != OneQ16 && mag < mn;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= '{cmd: in_data_i.command, in_w: in_data_i.in_w, last: in_data_i.last_vector};
      for (int i = 1; i < Depth; i++) sd_q[i] <= sd_q[i-1];
      for (int i = 3; i < Depth; i++) cl_q[i] <= cl_q[i-1];
      for (int k = 0; k < 4; k++) rr_q[k] <= r[k];
      byp_q <= (sd_q[1].cmd != CmdPoint) || (r[3] == OneQ16);
      wd_q <= clamp ? $signed(mn) : r[3];
      cl_q[2] <= clamp;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    hpt_div u_div (.clk_i, .en_i(adv), .bypass_i(byp_q), .n_i(rr_q[k]),
                   .d_i(wd_q), .q_o(q[k]));
  end

  logic signed [31:0] w_pipe_q [DivSteps+2];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_pipe_q[0] <= rr_q[3];
      for (int i = 1; i <= DivSteps + 1; i++) w_pipe_q[i] <= w_pipe_q[i-1];
    end
  end

  side_t so;
  assign so = sd_q[Depth-1];
  assign pipe_vld = vld_q[Depth-1];
  always_comb begin
    pipe_beat.out_x = q[0];
    pipe_beat.out_y = q[1];
    pipe_beat.out_z = q[2];
    case (so.cmd)
      CmdPoint: pipe_beat.out_w = OneQ16;
      CmdHomog: pipe_beat.out_w = w_pipe_q[DivSteps+1];
      default:  pipe_beat.out_w = so.in_w;
    endcase
    pipe_beat.w_clamped = cl_q[Depth-1];
    pipe_beat.last_result = so.last;
  end

  // hold the head beat when the receiver stalls, so the pipeline can move on
  assign skid_vld_d = skid_vld_q ? !out_ready_i : (pipe_vld && !out_ready_i);
  assign skid_d = skid_vld_q ? skid_q : pipe_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    skid_q <= skid_d;
  end

  assign out_valid_o = skid_vld_q || pipe_vld;
  assign out_data_o = skid_vld_q ? skid_q : pipe_beat;

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o)) else $error("payload moved");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == !skid_vld_q) else $error("ready wrong");
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.w_clamped |-> out_data_o.out_w == OneQ16) else $error("clamp");
endmodule

/* bench/homogeneous_point_transform_test.sv */
// Testbench: directed and random vector transforms checked against a Q16.16 matrix predictor
module homogeneous_point_transform_test;
  import hpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 120;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MinW-1:0] cfg_data = '0;

  logic signed [31:0] matrix_q[Entries];
  logic [MinW-1:0] min_w_q;
  out_beat_t expected_beats[$];
  int unsigned failures = 0;
  int unsigned cycles = 0;
  int unsigned hold_len = 0;
  int unsigned stall_n = 0;
  bit idle_on = 1'b1;

  homogeneous_point_transform i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("homogeneous_point_transform test failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] sat_q16(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    if (v < -68'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] column_sum(input logic signed [31:0] v[4],
                                                    input int col);
    logic signed [67:0] acc, a, b;
    acc = '0;
    for (int r = 0; r < 4; r++) begin
      a = 68'(v[r]);
      b = 68'(matrix_q[r*4+col]);
      acc += a * b;
    end
    return sat_q16((acc + 68'sd32768) >>> 16);
  endfunction

  function automatic logic signed [31:0] divide_by_w(input logic signed [31:0] n,
                                                     input logic signed [31:0] d);
    longint sn, sd;
    longint unsigned un, ud, q;
    logic signed [67:0] s;
    sn = longint'(n);
    sd = longint'(d);
    un = (sn < 0) ? -sn : sn;
    ud = (sd < 0) ? -sd : sd;
    if (ud == 0) ud = 1;
    q = (un * 65536 + ud / 2) / ud;
    s = $signed({4'b0, q});
    if ((sn < 0) != (sd < 0)) s = -s;
    return sat_q16(s);
  endfunction

  function automatic bit transform_vector(input in_beat_t b, output out_beat_t r);
    logic signed [31:0] v[4], res[4], w;
    longint mag, minm;
    r = '0;
    if (b.command == CmdLoad) begin
      matrix_q[b.entry_index] = b.entry_value;
      return 1'b0;
    end
    v[0] = b.in_x;
    v[1] = b.in_y;
    v[2] = b.in_z;
    v[3] = (b.command == CmdPoint) ? OneQ16 : (b.command == CmdDir) ? 32'sd0 : b.in_w;
    for (int c = 0; c < 4; c++) res[c] = column_sum(v, c);
    r.out_w = res[3];
    if (b.command == CmdPoint) begin
      w = res[3];
      if (w != OneQ16) begin
        minm = (min_w_q == '0) ? 64'sd1 : longint'(min_w_q);
        mag = (w < 0) ? -longint'(w) : longint'(w);
        if (mag < minm) begin
          w = 32'(minm);
          r.w_clamped = 1'b1;
        end
        for (int c = 0; c < 3; c++) res[c] = divide_by_w(res[c], w);
      end
      r.out_w = OneQ16;
    end else if (b.command == CmdDir) begin
      r.out_w = b.in_w;
    end
    r.out_x = res[0];
    r.out_y = res[1];
    r.out_z = res[2];
    r.last_result = b.last_vector;
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (hold_len > 0) begin
      out_ready <= 1'b0;
      hold_len = hold_len - 1;
    end else if (stall_n > 0) begin
      out_ready <= 1'b0;
      stall_n <= stall_n - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_n <= $urandom_range(0, 11);
    end else begin
      out_ready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    out_beat_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with no expectation");
        failures++;
      end else begin
        e = expected_beats.pop_front();
        if (out_data.out_x !== e.out_x) begin
          $error("out_x expected %0d actual %0d", e.out_x, out_data.out_x); failures++;
        end
        if (out_data.out_y !== e.out_y) begin
          $error("out_y expected %0d actual %0d", e.out_y, out_data.out_y); failures++;
        end
        if (out_data.out_z !== e.out_z) begin
          $error("out_z expected %0d actual %0d", e.out_z, out_data.out_z); failures++;
        end
        if (out_data.out_w !== e.out_w) begin
          $error("out_w expected %0d actual %0d", e.out_w, out_data.out_w); failures++;
        end
        if (out_data.w_clamped !== e.w_clamped) begin
          $error("w_clamped expected %0d actual %0d", e.w_clamped, out_data.w_clamped);
          failures++;
        end
        if (out_data.last_result !== e.last_result) begin
          $error("last_result expected %0d actual %0d", e.last_result, out_data.last_result);
          failures++;
        end
      end
    end
  end

  task automatic send_beat(input in_beat_t b);
    out_beat_t r;
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk_i); while (!in_ready);
    if (transform_vector(b, r)) expected_beats.push_back(r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_min_w(input logic [MinW-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    min_w_q = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $signed($urandom_range(0, 262144)) - 32'sd131072;
      3: return $signed($urandom_range(0, 511)) - 32'sd256;
      4: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 8388608)) - 32'sd4194304;
    endcase
  endfunction

  function automatic in_beat_t vector_beat(input cmd_e c, input logic signed [31:0] x,
                                           input logic signed [31:0] y,
                                           input logic signed [31:0] z,
                                           input logic signed [31:0] w);
    in_beat_t b;
    b.command = c;
    b.entry_index = 4'($urandom);
    b.entry_value = $urandom;
    b.in_x = x;
    b.in_y = y;
    b.in_z = z;
    b.in_w = w;
    b.last_vector = 1'($urandom);
    return b;
  endfunction

  function automatic in_beat_t load_beat(input int idx, input logic signed [31:0] value);
    in_beat_t b;
    b = vector_beat(CmdLoad, $urandom, $urandom, $urandom, $urandom);
    b.entry_index = 4'(idx);
    b.entry_value = value;
    return b;
  endfunction

  function automatic in_beat_t random_beat();
    cmd_e c;
    c = cmd_e'($urandom_range(1, 3));
    if ($urandom_range(0, 15) == 0) return load_beat($urandom_range(0, 15), rand_q16());
    return vector_beat(c, rand_q16(), rand_q16(), rand_q16(), rand_q16());
  endfunction

  task automatic test_directed();
    send_beat(vector_beat(CmdPoint, 32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sd5));
    send_beat(vector_beat(CmdHomog, 32'sh80000000, 32'sh7fffffff, OneQ16, 32'sh80000000));
    send_beat(vector_beat(CmdDir, 32'sd3, -32'sd3, 32'sh7fffffff, 32'sh7fffffff));
    send_beat(load_beat(15, 32'sd32768));
    send_beat(vector_beat(CmdPoint, OneQ16, -OneQ16, 32'sh7fffffff, 32'sd0));
    send_beat(load_beat(15, -32'sd1));
    send_beat(vector_beat(CmdPoint, OneQ16, 32'sd7, -32'sd9, 32'sd0));
    send_beat(load_beat(15, 32'sd0));
    send_beat(vector_beat(CmdPoint, 32'sd1, -32'sd1, 32'sd100, 32'sd0));
    send_beat(load_beat(0, 32'sh7fffffff));
    send_beat(load_beat(4, 32'sh7fffffff));
    send_beat(vector_beat(CmdHomog, 32'sh7fffffff, 32'sh7fffffff, 32'sd1, 32'sh80000000));
    send_beat(vector_beat(CmdDir, 32'sh80000000, 32'sh80000000, 32'sd1, -32'sd1));
    send_beat(load_beat(15, OneQ16));
    send_beat(load_beat(0, OneQ16));
    send_beat(load_beat(4, 32'sd0));
    send_beat(vector_beat(CmdPoint, 32'sd12345, -32'sd54321, 32'sd7, 32'sd0));
  endtask

  task automatic load_random_matrix();
    for (int i = 0; i < Entries; i++) begin
      if (i % 5 == 0) send_beat(load_beat(i, rand_q16() | 32'sd65536));
      else if (i % 4 == 3) send_beat(load_beat(i, $signed($urandom_range(0, 8191)) - 32'sd4096));
      else send_beat(load_beat(i, rand_q16()));
    end
  endtask

  task automatic test_random_phase(input logic [MinW-1:0] min_w, input int n);
    write_min_w(min_w);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) load_random_matrix();
      send_beat(random_beat());
    end
  endtask

  task automatic test_backpressure();
    hold_len = 500;
    for (int i = 0; i < 150; i++) send_beat(random_beat());
    wait_drained();
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    for (int i = 0; i < 250; i++) send_beat(random_beat());
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < Entries; i++) matrix_q[i] = (i % 5 == 0) ? OneQ16 : 32'sd0;
    min_w_q = MinWReset;
    @(posedge clk_i);
    test_directed();
    test_random_phase(17'd0, 200);
    test_random_phase(17'h1ffff, 200);
    test_random_phase(17'd65536, 200);
    test_random_phase(17'd1, 200);
    test_random_phase(17'($urandom), 200);
    test_backpressure();
    test_no_idle();
    wait_drained();
    if (failures == 0 && expected_beats.size() == 0) begin
      $display("homogeneous_point_transform test passed");
    end else begin
      $display("homogeneous_point_transform test failed");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/hpt_pkg.sv
rtl/hpt_lane.sv
rtl/hpt_div.sv
rtl/homogeneous_point_transform.sv
bench/homogeneous_point_transform_test.sv
